>>> rtl/bfa_pkg.sv
// Shared constants, types and codes of the bitmap first-fit allocator.
`timescale 1ns / 1ps
package bfa_pkg;

  // Map geometry
  localparam int unsigned NUM_UNITS = 1024;
  localparam int unsigned UNIT_W    = $clog2(NUM_UNITS);
  localparam int unsigned CNT_W     = UNIT_W + 1;

  // Field widths fixed by the interface
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned FREE_W  = 10;
  localparam int unsigned START_W = 10;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned HEAP_W  = 11;

  localparam logic [CNT_W-1:0]  NUM_UNITS_C = CNT_W'(NUM_UNITS);
  localparam logic [HEAP_W-1:0] HEAP_RESET  = HEAP_W'(1024);

  // Map entry encodings: bit 0 used, bit 1 continues into next unit
  localparam int unsigned USED_IDX = 0;
  localparam int unsigned CONT_IDX = 1;
  localparam logic [1:0] MAP_FREE = 2'b00;
  localparam logic [1:0] MAP_USED = 2'b01;
  localparam logic [1:0] MAP_BOTH = 2'b11;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_NOSPACE = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_BADFREE = STAT_W'(2);

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_RESULT
  } bfa_state_e;

  // Map write port
  typedef struct packed {
    logic              en;
    logic [UNIT_W-1:0] addr;
    logic [1:0]        data;
  } bfa_wr_t;

  // Finished result from the sequencer
  typedef struct packed {
    logic               valid;
    logic [STAT_W-1:0]  status;
    logic [START_W-1:0] start_unit;
  } bfa_fin_t;

endpackage

>>> rtl/bfa_if.sv
// Request and response channel interfaces of the allocator.
`timescale 1ns / 1ps
interface bfa_req_if;
  import bfa_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] alloc_size;
  logic [FREE_W-1:0] free_unit;

  modport source (output valid, mode, alloc_size, free_unit, input ready);
  modport sink   (input valid, mode, alloc_size, free_unit, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [START_W-1:0] start_unit;

  modport source (output valid, status, start_unit, input ready);
  modport sink   (input valid, status, start_unit, output ready);
endinterface

>>> rtl/bfa_map.sv
// Usage map memory: one write port, one registered read port.
`timescale 1ns / 1ps
module bfa_map
  import bfa_pkg::*;
(
  input  logic              clk_i,
  input  bfa_wr_t           wr_i,
  input  logic [UNIT_W-1:0] rd_addr_i,
  output logic [1:0]        rd_data_o
);

  logic [1:0] mem_q [NUM_UNITS];
  logic [1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/bfa_ctrl.sv
// Sequencer and scan unit: map clear, first-fit scan, run marking, free walk.
`timescale 1ns / 1ps
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bfa_req_if.sink           req_i,
  input  logic [CNT_W-1:0]  limit_i,
  input  logic              out_free_i,
  output logic [UNIT_W-1:0] rd_addr_o,
  input  logic [1:0]        rd_data_i,
  output bfa_wr_t           wr_o,
  output bfa_fin_t          fin_o
);

  bfa_state_e         st_q, st_d;
  logic [CNT_W-1:0]   addr_q, addr_d;
  logic [UNIT_W-1:0]  chk_q, chk_d;
  logic               pend_q, pend_d;
  logic [CNT_W-1:0]   run_q, run_d;
  logic [UNIT_W-1:0]  start_q, start_d;
  logic [CNT_W-1:0]   size_q, size_d;
  logic [UNIT_W-1:0]  end_q, end_d;
  logic [STAT_W-1:0]  stat_q, stat_d;
  logic [UNIT_W-1:0]  res_q, res_d;

  logic [CNT_W-1:0]   run_inc;
  logic [CNT_W-1:0]   limit_m1;
  logic               chk_last;
  logic               accept;

  assign accept   = req_i.valid && req_i.ready;
  assign run_inc  = run_q + CNT_W'(1);
  assign limit_m1 = limit_i - CNT_W'(1);
  assign chk_last = ({1'b0, chk_q} == limit_m1);

  assign req_i.ready = (st_q == ST_IDLE);
  assign rd_addr_o   = addr_q[UNIT_W-1:0];

  assign fin_o.valid      = (st_q == ST_RESULT);
  assign fin_o.status     = stat_q;
  assign fin_o.start_unit = START_W'(res_q);

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      addr_q <= '0;
      pend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      addr_q <= addr_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q   <= chk_d;
    run_q   <= run_d;
    start_q <= start_d;
    size_q  <= size_d;
    end_q   <= end_d;
    stat_q  <= stat_d;
    res_q   <= res_d;
  end

  // Next state and map accesses
  always_comb begin
    st_d    = st_q;
    addr_d  = addr_q;
    chk_d   = chk_q;
    pend_d  = pend_q;
    run_d   = run_q;
    start_d = start_q;
    size_d  = size_q;
    end_d   = end_q;
    stat_d  = stat_q;
    res_d   = res_q;
    wr_o    = '{en: 1'b0, addr: addr_q[UNIT_W-1:0], data: MAP_FREE};

    unique case (st_q)
      // Sweep zeros through the map after reset
      ST_CLEAR: begin
        wr_o.en = 1'b1;
        addr_d  = addr_q + CNT_W'(1);
        if (addr_q == NUM_UNITS_C - CNT_W'(1)) begin
          st_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        pend_d = 1'b0;
        if (accept) begin
          res_d = '0;
          if (req_i.mode == MODE_ALLOC) begin
            if (req_i.alloc_size == '0 || CNT_W'(req_i.alloc_size) > limit_i) begin
              stat_d = STAT_NOSPACE;
              st_d   = ST_RESULT;
            end else begin
              size_d  = CNT_W'(req_i.alloc_size);
              addr_d  = '0;
              run_d   = '0;
              start_d = '0;
              st_d    = ST_SCAN;
            end
          end else begin
            if (CNT_W'(req_i.free_unit) >= limit_i) begin
              stat_d = STAT_BADFREE;
              st_d   = ST_RESULT;
            end else begin
              addr_d = CNT_W'(req_i.free_unit);
              st_d   = ST_FREE;
            end
          end
        end
      end

      // Read one unit per cycle, evaluate each unit once its registered read data returns
      ST_SCAN: begin
        if (addr_q < limit_i) begin
          pend_d = 1'b1;
          chk_d  = addr_q[UNIT_W-1:0];
          addr_d = addr_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (rd_data_i[USED_IDX]) begin
            run_d   = '0;
            start_d = chk_q + UNIT_W'(1);
            if (chk_last) begin
              stat_d = STAT_NOSPACE;
              st_d   = ST_RESULT;
            end
          end else if (run_inc == size_q) begin
            end_d  = UNIT_W'(CNT_W'(start_q) + size_q - CNT_W'(1));
            addr_d = CNT_W'(start_q);
            pend_d = 1'b0;
            st_d   = ST_MARK;
          end else begin
            run_d = run_inc;
            if (chk_last) begin
              stat_d = STAT_NOSPACE;
              st_d   = ST_RESULT;
            end
          end
        end
      end

      // Mark the found run; last unit gets no continuation
      ST_MARK: begin
        wr_o.en   = 1'b1;
        wr_o.data = (addr_q[UNIT_W-1:0] == end_q) ? MAP_USED : MAP_BOTH;
        addr_d    = addr_q + CNT_W'(1);
        if (addr_q[UNIT_W-1:0] == end_q) begin
          stat_d = STAT_OK;
          res_d  = start_q;
          st_d   = ST_RESULT;
        end
      end

      // Walk the block: read ahead, clear each unit once its registered read data returns
      ST_FREE: begin
        pend_d = 1'b1;
        chk_d  = addr_q[UNIT_W-1:0];
        addr_d = addr_q + CNT_W'(1);
        if (pend_q) begin
          wr_o.en   = 1'b1;
          wr_o.addr = chk_q;
          if (!rd_data_i[CONT_IDX] || chk_q == UNIT_W'(NUM_UNITS - 1)) begin
            stat_d = STAT_OK;
            res_d  = '0;
            pend_d = 1'b0;
            st_d   = ST_RESULT;
          end
        end
      end

      // Hand the result to the output register
      ST_RESULT: begin
        if (out_free_i) begin
          st_d = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bitmap_first_fit_allocator_top.sv
// Top level of the bitmap first-fit allocator.
//
//   channel  dir  handshake            payload
//   req_i    in   valid / ready        mode, alloc_size, free_unit
//   rsp_o    out  valid / ready        status, start_unit
//   cfg      in   cfg_we_i (no stall)  cfg_wdata_i = heap_units
//
// After reset the map is swept clear; no request is taken then.
// Allocate: the single map read port scans one unit per cycle and the write port
// marks one unit per cycle.
// One transaction is in work at a time; a finished result waits in the
// output register, and the sequencer holds its result until that register frees.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator_top
  import bfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bfa_req_if.sink           req_i,
  bfa_rsp_if.source         rsp_o,
  input  logic              cfg_we_i,
  input  logic [HEAP_W-1:0] cfg_wdata_i
);

  logic [HEAP_W-1:0]  heap_q, heap_d;
  logic [CNT_W-1:0]   limit;
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_status_q, out_status_d;
  logic [START_W-1:0] out_start_q, out_start_d;
  logic               out_free;
  logic [UNIT_W-1:0]  rd_addr;
  logic [1:0]         rd_data;
  bfa_wr_t            map_wr;
  bfa_fin_t           fin;

  // Heap size register, clamped to the map size
  assign heap_d = cfg_we_i ? cfg_wdata_i : heap_q;
  assign limit  = (heap_q > HEAP_W'(NUM_UNITS)) ? NUM_UNITS_C : CNT_W'(heap_q);

  // Output register
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    if (out_free) begin
      out_valid_d  = fin.valid;
      out_status_d = fin.status;
      out_start_d  = fin.start_unit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= HEAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      heap_q      <= heap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.start_unit = out_start_q;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .limit_i    (limit),
    .out_free_i (out_free),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_o       (map_wr),
    .fin_o      (fin)
  );

  bfa_map u_map (
    .clk_i     (clk_i),
    .wr_i      (map_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule
